### design/bra_pkg.sv
// Shared types and constants for the bitmap run allocator.
// No dependencies; used by every module in the design folder except bra_ram.
package bra_pkg;

    localparam int MAP_BYTES = 128;
    localparam int ADDR_W    = $clog2(MAP_BYTES);
    localparam int BYTE_W    = 8;
    localparam logic [7:0] RESET_USED_BYTES = 8'd128;

    typedef enum logic [1:0] {
        MODE_SCAN  = 2'd0,
        MODE_WRITE = 2'd1,
        MODE_TEST  = 2'd2,
        MODE_CLEAR = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        STS_OK     = 2'd0,
        STS_NO_RUN = 2'd1,
        STS_RANGE  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_ACCESS,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic    capture;
        logic    rd;
        logic    scan_step;
        logic    wr;
        logic    clr;
        logic    set_status;
        status_t status;
        logic    sample_bit;
        logic    load_out;
    } ctl_cmd_t;

    typedef struct packed {
        mode_t mode;
        logic  oor;
        logic  len_zero;
        logic  no_bytes;
        logic  hit;
        logic  last;
    } dp_sts_t;

endpackage

### design/bra_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bra_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### design/bra_datapath.sv
// Datapath: request registers, mark store with per-byte valid flags,
// byte-wise run scanner and result registers. Depends on bra_pkg, bra_ram.
module bra_datapath (
    input  logic               aclk,
    input  logic               aresetn,
    input  bra_pkg::ctl_cmd_t  cmd,
    output bra_pkg::dp_sts_t   sts,
    input  logic [1:0]         s_mode,
    input  logic [9:0]         s_bit_index,
    input  logic               s_write_value,
    input  logic [10:0]        s_run_length,
    input  logic               cfg_valid,
    input  logic [7:0]         cfg_data,
    output logic [1:0]         m_status,
    output logic [9:0]         m_run_start,
    output logic               m_bit_read
);

    logic [7:0]                    used_bytes_reg;
    logic [bra_pkg::MAP_BYTES-1:0] valid_reg;
    bra_pkg::mode_t                mode_reg;
    logic [9:0]                    idx_reg;
    logic                          val_reg;
    logic [10:0]                   len_reg;
    logic [bra_pkg::ADDR_W-1:0]    addr_reg;
    logic [bra_pkg::ADDR_W-1:0]    byte_reg;
    logic                          rvld_reg;
    logic [10:0]                   run_reg;
    bra_pkg::status_t              status_reg;
    logic [9:0]                    start_reg;
    logic                          bit_reg;
    bra_pkg::status_t              out_status_reg;
    logic [9:0]                    out_start_reg;
    logic                          out_bit_reg;

    logic [7:0]                    nbytes;
    logic [10:0]                   nbits;
    logic [bra_pkg::BYTE_W-1:0]    ram_rdata;
    logic [bra_pkg::BYTE_W-1:0]    rdata_eff;
    logic [bra_pkg::BYTE_W-1:0]    sel_mask;
    logic [bra_pkg::BYTE_W-1:0]    wdata;
    logic [10:0]                   run_v;
    logic                          hit_v;
    logic [2:0]                    fpos_v;
    logic [10:0]                   start_v;

    assign nbytes = (used_bytes_reg > 8'(bra_pkg::MAP_BYTES)) ?
                    8'(bra_pkg::MAP_BYTES) : used_bytes_reg;
    assign nbits  = {nbytes, 3'b000};

    assign rdata_eff = rvld_reg ? ram_rdata : '0;
    assign sel_mask  = 8'(1) << idx_reg[2:0];
    assign wdata     = val_reg ? (rdata_eff | sel_mask) : (rdata_eff & ~sel_mask);

    always_comb begin
        run_v  = run_reg;
        hit_v  = 1'b0;
        fpos_v = 3'd0;
        for (int k = 0; k < bra_pkg::BYTE_W; k++) begin
            if (!hit_v) begin
                if (rdata_eff[k]) begin
                    run_v = 11'd0;
                end else begin
                    run_v = run_v + 11'd1;
                end
                if (run_v == len_reg) begin
                    hit_v  = 1'b1;
                    fpos_v = 3'(k);
                end
            end
        end
    end

    assign start_v = {1'b0, byte_reg, fpos_v} + 11'd1 - len_reg;

    assign sts.mode     = mode_reg;
    assign sts.oor      = {1'b0, idx_reg} >= nbits;
    assign sts.len_zero = (len_reg == 11'd0);
    assign sts.no_bytes = (nbytes == 8'd0);
    assign sts.hit      = hit_v;
    assign sts.last     = ({1'b0, byte_reg} == (nbytes - 8'd1));

    bra_ram #(
        .WIDTH (bra_pkg::BYTE_W),
        .DEPTH (bra_pkg::MAP_BYTES)
    ) u_store (
        .aclk  (aclk),
        .we    (cmd.wr),
        .waddr (idx_reg[9:3]),
        .wdata (wdata),
        .re    (cmd.rd),
        .raddr (addr_reg),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_bytes_reg <= bra_pkg::RESET_USED_BYTES;
            valid_reg      <= '0;
        end else begin
            if (cfg_valid) begin
                used_bytes_reg <= cfg_data;
            end
            if (cmd.clr) begin
                valid_reg <= '0;
            end else if (cmd.wr) begin
                valid_reg[idx_reg[9:3]] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            mode_reg  <= bra_pkg::mode_t'(s_mode);
            idx_reg   <= s_bit_index;
            val_reg   <= s_write_value;
            len_reg   <= s_run_length;
            addr_reg  <= (bra_pkg::mode_t'(s_mode) == bra_pkg::MODE_SCAN) ?
                         '0 : s_bit_index[9:3];
            run_reg   <= 11'd0;
            start_reg <= 10'd0;
            bit_reg   <= 1'b0;
        end else begin
            if (cmd.rd) begin
                addr_reg <= addr_reg + 1'b1;
                byte_reg <= addr_reg;
                rvld_reg <= valid_reg[addr_reg];
            end
            if (cmd.scan_step) begin
                run_reg <= run_v;
                if (hit_v) begin
                    start_reg <= start_v[9:0];
                end
            end
            if (cmd.sample_bit) begin
                bit_reg <= rdata_eff[idx_reg[2:0]];
            end
        end
        if (cmd.set_status) begin
            status_reg <= cmd.status;
        end
        if (cmd.load_out) begin
            out_status_reg <= status_reg;
            out_start_reg  <= start_reg;
            out_bit_reg    <= bit_reg;
        end
    end

    assign m_status    = out_status_reg;
    assign m_run_start = out_start_reg;
    assign m_bit_read  = out_bit_reg;

endmodule

### design/bra_ctrl.sv
// Controller state machine and result valid flag.
// Depends on bra_pkg; drives the command struct of bra_datapath.
module bra_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    output logic               m_valid,
    input  logic               m_ready,
    input  bra_pkg::dp_sts_t   sts,
    output bra_pkg::ctl_cmd_t  cmd
);

    bra_pkg::state_t state_reg, state_next;
    logic            m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= bra_pkg::S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.status = bra_pkg::STS_OK;
        s_ready    = 1'b0;
        unique case (state_reg)
            bra_pkg::S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = bra_pkg::S_DECODE;
                end
            end
            bra_pkg::S_DECODE: begin
                unique case (sts.mode)
                    bra_pkg::MODE_SCAN: begin
                        if (sts.len_zero) begin
                            cmd.set_status = 1'b1;
                            cmd.status     = bra_pkg::STS_OK;
                            state_next     = bra_pkg::S_FINISH;
                        end else if (sts.no_bytes) begin
                            cmd.set_status = 1'b1;
                            cmd.status     = bra_pkg::STS_NO_RUN;
                            state_next     = bra_pkg::S_FINISH;
                        end else begin
                            cmd.rd     = 1'b1;
                            state_next = bra_pkg::S_SCAN;
                        end
                    end
                    bra_pkg::MODE_WRITE, bra_pkg::MODE_TEST: begin
                        if (sts.oor) begin
                            cmd.set_status = 1'b1;
                            cmd.status     = bra_pkg::STS_RANGE;
                            state_next     = bra_pkg::S_FINISH;
                        end else begin
                            cmd.rd     = 1'b1;
                            state_next = bra_pkg::S_ACCESS;
                        end
                    end
                    bra_pkg::MODE_CLEAR: begin
                        cmd.clr        = 1'b1;
                        cmd.set_status = 1'b1;
                        cmd.status     = bra_pkg::STS_OK;
                        state_next     = bra_pkg::S_FINISH;
                    end
                    default: begin
                        state_next = bra_pkg::S_IDLE;
                    end
                endcase
            end
            bra_pkg::S_SCAN: begin
                cmd.scan_step = 1'b1;
                if (sts.hit) begin
                    cmd.set_status = 1'b1;
                    cmd.status     = bra_pkg::STS_OK;
                    state_next     = bra_pkg::S_FINISH;
                end else if (sts.last) begin
                    cmd.set_status = 1'b1;
                    cmd.status     = bra_pkg::STS_NO_RUN;
                    state_next     = bra_pkg::S_FINISH;
                end else begin
                    cmd.rd = 1'b1;
                end
            end
            bra_pkg::S_ACCESS: begin
                if (sts.mode == bra_pkg::MODE_WRITE) begin
                    cmd.wr = 1'b1;
                end else begin
                    cmd.sample_bit = 1'b1;
                end
                cmd.set_status = 1'b1;
                cmd.status     = bra_pkg::STS_OK;
                state_next     = bra_pkg::S_FINISH;
            end
            bra_pkg::S_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.load_out = 1'b1;
                    state_next   = bra_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = bra_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    assign m_valid = m_valid_reg;

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!m_valid_reg || m_ready))
        else $error("result register overwritten while pending");

    a_load_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |=> m_valid_reg)
        else $error("loaded result not presented");

    a_write_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.wr |-> (sts.mode == bra_pkg::MODE_WRITE && !sts.oor))
        else $error("store written outside a valid write");

    a_one_access: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.wr, cmd.clr, cmd.sample_bit, cmd.scan_step}))
        else $error("conflicting datapath commands");

endmodule

### design/bitmap_run_allocator_top.sv
// Request flow: IDLE accepts, DECODE sends clear-all, out-of-range and zero-length or
// no-byte scan requests straight to FINISH, write and test through ACCESS, and scan through
// SCAN until a hit or the last byte; FINISH loads the output register once it is free.
// One request at a time; the next is taken the cycle after its result enters the output
// register. The scan reads one store byte per cycle. Reset (synchronous, active low)
// empties the store via per-byte valid flags and sets used_bytes to 128; no clearing pass.
module bitmap_run_allocator_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_mode,
    input  logic [9:0]  s_bit_index,
    input  logic        s_write_value,
    input  logic [10:0] s_run_length,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [9:0]  m_run_start,
    output logic        m_bit_read,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data
);

    bra_pkg::ctl_cmd_t cmd;
    bra_pkg::dp_sts_t  sts;

    assign cfg_ready = 1'b1;

    bra_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    bra_datapath u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .sts           (sts),
        .s_mode        (s_mode),
        .s_bit_index   (s_bit_index),
        .s_write_value (s_write_value),
        .s_run_length  (s_run_length),
        .cfg_valid     (cfg_valid),
        .cfg_data      (cfg_data),
        .m_status      (m_status),
        .m_run_start   (m_run_start),
        .m_bit_read    (m_bit_read)
    );

endmodule

### sim/tb.sv
// Self-checking testbench for bitmap_run_allocator_top: directed and random requests.
// A scoreboard class keeps its own copy of the mark store and checks each result in order.
// Depends on bra_pkg and the RTL in the design folder.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import bra_pkg::*;

    typedef struct {
        status_t    status;
        logic [9:0] run_start;
        logic       bit_read;
    } alloc_reply_t;

    class alloc_scoreboard;
        logic [7:0]   marks [MAP_BYTES];
        logic [7:0]   used_bytes;
        alloc_reply_t replies_due [$];
        int           errors;
        int           replies_seen;

        function new();
            foreach (marks[i]) marks[i] = '0;
            used_bytes   = RESET_USED_BYTES;
            errors       = 0;
            replies_seen = 0;
        endfunction

        function int used_bits();
            return ((used_bytes > MAP_BYTES) ? MAP_BYTES : int'(used_bytes)) * BYTE_W;
        endfunction

        function void set_used(logic [7:0] value);
            used_bytes = value;
        endfunction

        function int pending();
            return replies_due.size();
        endfunction

        function void note_request(mode_t mode, logic [9:0] idx, logic value,
                                   logic [10:0] len);
            alloc_reply_t r;
            int nbits;
            int run;
            r.status    = STS_OK;
            r.run_start = '0;
            r.bit_read  = 1'b0;
            nbits       = used_bits();
            case (mode)
                MODE_SCAN: begin
                    if (len != 0) begin
                        r.status = STS_NO_RUN;
                        run = 0;
                        for (int p = 0; p < nbits; p++) begin
                            run = marks[p / BYTE_W][p % BYTE_W] ? 0 : run + 1;
                            if (run == len) begin
                                r.status    = STS_OK;
                                r.run_start = 10'(p + 1 - int'(len));
                                break;
                            end
                        end
                    end
                end
                MODE_WRITE, MODE_TEST: begin
                    if (int'(idx) >= nbits) begin
                        r.status = STS_RANGE;
                    end else if (mode == MODE_WRITE) begin
                        marks[idx / BYTE_W][idx % BYTE_W] = value;
                    end else begin
                        r.bit_read = marks[idx / BYTE_W][idx % BYTE_W];
                    end
                end
                MODE_CLEAR: begin
                    foreach (marks[i]) marks[i] = '0;
                end
            endcase
            replies_due.push_back(r);
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 60) begin
                $display("%0t ERROR %s", $time, msg);
            end
        endtask

        task check_result(logic [1:0] status, logic [9:0] start, logic bit_rd);
            alloc_reply_t r;
            replies_seen++;
            if (replies_due.size() == 0) begin
                report($sformatf("result %0d arrived with no request outstanding",
                                 replies_seen));
                return;
            end
            r = replies_due.pop_front();
            if (status !== r.status) begin
                report($sformatf("result %0d status %0d, expected %0d",
                                 replies_seen, status, r.status));
            end
            if (start !== r.run_start) begin
                report($sformatf("result %0d run_start %0d, expected %0d",
                                 replies_seen, start, r.run_start));
            end
            if (bit_rd !== r.bit_read) begin
                report($sformatf("result %0d bit_read %b, expected %b",
                                 replies_seen, bit_rd, r.bit_read));
            end
        endtask
    endclass

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        s_valid       = 1'b0;
    logic        s_ready;
    logic [1:0]  s_mode        = '0;
    logic [9:0]  s_bit_index   = '0;
    logic        s_write_value = 1'b0;
    logic [10:0] s_run_length  = '0;
    logic        m_valid;
    logic        m_ready       = 1'b0;
    logic [1:0]  m_status;
    logic [9:0]  m_run_start;
    logic        m_bit_read;
    logic        cfg_valid     = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_data      = '0;

    alloc_scoreboard sb;
    bit              steady = 1'b0;

    always #5 aclk = ~aclk;

    bitmap_run_allocator_top dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_mode        (s_mode),
        .s_bit_index   (s_bit_index),
        .s_write_value (s_write_value),
        .s_run_length  (s_run_length),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_run_start   (m_run_start),
        .m_bit_read    (m_bit_read),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    task automatic send_request(mode_t mode, int idx, bit value, int len);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_mode        <= mode;
        s_bit_index   <= 10'(idx);
        s_write_value <= value;
        s_run_length  <= 11'(len);
        do @(posedge aclk); while (!s_ready);
        sb.note_request(mode, 10'(idx), value, 11'(len));
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    task automatic write_used_bytes(logic [7:0] value);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.set_used(value);
    endtask

    // result side
    initial begin
        int stall;
        wait (aresetn);
        forever begin
            stall = steady ? 0 : $urandom_range(0, 9);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            sb.check_result(m_status, m_run_start, m_bit_read);
        end
    end

    initial begin
        int         pick;
        int         nbits;
        int         idx;
        int         len;
        int         fill_pct;
        int         phase_len;
        int         random_sent;
        mode_t      mode;
        bit         value;
        logic [7:0] used;
        sb = new();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty store, full width
        send_request(MODE_TEST, 0, 1'b0, 1);
        send_request(MODE_SCAN, 0, 1'b0, 0);
        send_request(MODE_SCAN, 0, 1'b0, 1024);
        send_request(MODE_SCAN, 0, 1'b0, 1025);
        send_request(MODE_SCAN, 0, 1'b0, 2047);
        // marks at both ends
        send_request(MODE_WRITE, 0, 1'b1, 1);
        send_request(MODE_WRITE, 1023, 1'b1, 1);
        send_request(MODE_TEST, 1023, 1'b0, 1);
        send_request(MODE_SCAN, 0, 1'b0, 1);
        send_request(MODE_SCAN, 0, 1'b0, 1022);
        send_request(MODE_SCAN, 0, 1'b0, 1023);
        // one byte in use
        write_used_bytes(8'd1);
        send_request(MODE_WRITE, 8, 1'b1, 1);
        send_request(MODE_TEST, 1023, 1'b0, 1);
        send_request(MODE_SCAN, 0, 1'b0, 8);
        send_request(MODE_SCAN, 0, 1'b0, 7);
        // nothing in use
        write_used_bytes(8'd0);
        send_request(MODE_TEST, 0, 1'b0, 1);
        send_request(MODE_SCAN, 0, 1'b0, 1);
        send_request(MODE_SCAN, 0, 1'b0, 0);
        // above store size saturates; hidden mark reappears
        write_used_bytes(8'd255);
        send_request(MODE_TEST, 1023, 1'b0, 1);
        send_request(MODE_WRITE, 1023, 1'b0, 1);
        send_request(MODE_SCAN, 0, 1'b0, 1023);
        send_request(MODE_CLEAR, 0, 1'b0, 0);
        send_request(MODE_TEST, 0, 1'b0, 1);
        send_request(MODE_SCAN, 0, 1'b0, 1024);

        random_sent = 0;
        while (random_sent < 750) begin
            pick = $urandom_range(0, 19);
            if (pick == 0) begin
                used = 8'd0;
            end else if (pick < 12) begin
                used = 8'($urandom_range(1, 16));
            end else if (pick < 17) begin
                used = 8'($urandom_range(17, 128));
            end else begin
                used = 8'($urandom_range(129, 255));
            end
            write_used_bytes(used);
            steady    = ($urandom_range(0, 3) == 0);
            fill_pct  = $urandom_range(30, 90);
            phase_len = $urandom_range(20, 80);
            nbits     = sb.used_bits();
            repeat (phase_len) begin
                pick = $urandom_range(0, 99);
                if (pick < 2) begin
                    mode = MODE_CLEAR;
                end else if (pick < 40) begin
                    mode = MODE_WRITE;
                end else if (pick < 60) begin
                    mode = MODE_TEST;
                end else begin
                    mode = MODE_SCAN;
                end
                if (nbits > 0 && $urandom_range(0, 9) != 0) begin
                    idx = $urandom_range(0, nbits - 1);
                end else begin
                    idx = $urandom_range(0, 1023);
                end
                value = ($urandom_range(0, 99) < fill_pct);
                pick  = $urandom_range(0, 19);
                if (pick == 0) begin
                    len = 0;
                end else if (pick < 14) begin
                    len = $urandom_range(1, 16);
                end else if (pick < 18) begin
                    len = $urandom_range(1, nbits + 2);
                end else begin
                    len = $urandom_range(0, 2047);
                end
                send_request(mode, idx, value, len);
                random_sent++;
            end
        end

        wait_drained();
        repeat (200) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #(10_000_000);
        $display("%0t ERROR timeout with %0d results outstanding", $time, sb.pending());
        $display("simulation failed");
        $finish;
    end

endmodule

### sim.f
design/bra_pkg.sv
design/bra_ram.sv
design/bra_datapath.sv
design/bra_ctrl.sv
design/bitmap_run_allocator_top.sv
sim/tb.sv
